// ----- rtl/qpht_pkg.sv -----
// shared types and constants of the quadratic probe hash table
package qpht_pkg;

	localparam int SIZE_W = 7;   // table size register and probe slot width
	localparam int KEY_W = 31;
	localparam int HASH_W = 34;  // 3*key+3 padded to a whole number of radix-4 digits
	localparam int HASH_DIGITS = HASH_W / 2;
	localparam int DIGIT_CNT_W = 5;
	localparam int ENTRY_W = KEY_W + 2;

	// slot tags
	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_LIVE = 2'd1;
	localparam logic [1:0] TAG_DELETED = 2'd2;

	// request types
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_DUPLICATE = 3'd1;
	localparam logic [2:0] ST_NO_SLOT = 3'd2;
	localparam logic [2:0] ST_FOUND = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_DELETED = 3'd5;
	localparam logic [2:0] ST_ABSENT = 3'd6;

	typedef struct packed {
		logic start;    // begin a new key: hash and reset the probe sequence
		logic advance;  // step to the next probe
	} pg_ctrl_t;

endpackage

// ----- rtl/quadratic_probe_hash_table.sv -----
// open-addressing key table with quadratic probing over one synchronous memory
// steps: the key of an accepted word is hashed and reduced by a radix-4 modulo over 17 digits,
//   then each probe reads its slot from memory and checks it, up to PROBE_LIMIT probes
// one word at a time: a new word is taken only once the last is through, also while its
//   result still waits to be read
// reset: a clearing pass over all TABLE_DEPTH slots marks every slot empty, no word is taken
//   until it ends; live count goes to zero and table_size to 64
module quadratic_probe_hash_table #(
	parameter int TABLE_DEPTH = 64,
	parameter int PROBE_LIMIT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [qpht_pkg::SIZE_W-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [qpht_pkg::KEY_W-1:0]    key,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [5:0]                    slot,
	output logic [6:0]                    live_count
);
	import qpht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int MAX_SIZE = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
	localparam logic [SIZE_W-1:0] MAX_SIZE_V = SIZE_W'(MAX_SIZE);
	localparam logic [PW-1:0] LAST_PROBE = PW'(PROBE_LIMIT - 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] table_size_q;
	logic [AW-1:0]     clr_addr_q;
	logic [PW-1:0]     probe_q;
	logic [CW-1:0]     count_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [2:0]        res_status_q;
	logic [SIZE_W-1:0] res_slot_q;
	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [5:0]        out_slot_q;
	logic [6:0]        out_count_q;

	// memory: {tag, key} per slot
	logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	pg_ctrl_t          pg_ctrl;
	logic              pg_ready;
	logic [SIZE_W-1:0] pg_slot;
	logic [SIZE_W-1:0] eff_size;

	logic       in_fire;
	logic       out_free;
	logic [1:0] rd_tag;
	logic       key_eq;
	logic       hit;
	logic       chk_done;
	logic       chk_write;
	logic [1:0] chk_tag;
	logic [2:0] chk_status;
	logic       cnt_inc;
	logic       cnt_dec;

	// size zero behaves as one, sizes past the table are clamped
	always_comb begin
		if (table_size_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (table_size_q > MAX_SIZE_V) begin
			eff_size = MAX_SIZE_V;
		end else begin
			eff_size = table_size_q;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign pg_ctrl.start = in_fire;
	assign pg_ctrl.advance = (state_q == S_CHECK) && !chk_done;

	qpht_probe_gen u_probe_gen (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pg_ctrl),
		.key    (key),
		.size   (eff_size),
		.ready  (pg_ready),
		.slot   (pg_slot)
	);

	// decision on the slot just read
	always_comb begin
		rd_tag = rd_q[ENTRY_W-1 -: 2];
		key_eq = (rd_q[KEY_W-1:0] == key_q);
		hit = (rd_tag == TAG_LIVE) && key_eq;
		chk_done = 1'b0;
		chk_write = 1'b0;
		chk_tag = TAG_LIVE;
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		case (op_q)
			OP_INSERT: begin
				chk_status = ST_NO_SLOT;
				if (rd_tag != TAG_LIVE) begin
					// first empty or deleted slot takes the key
					chk_done = 1'b1;
					chk_write = 1'b1;
					cnt_inc = 1'b1;
					chk_status = ST_INSERTED;
				end else if (key_eq) begin
					chk_done = 1'b1;
					chk_status = ST_DUPLICATE;
				end
			end
			OP_DELETE: begin
				chk_status = ST_ABSENT;
				if (rd_tag == TAG_EMPTY) begin
					chk_done = 1'b1;
				end else if (hit) begin
					chk_done = 1'b1;
					chk_write = 1'b1;
					chk_tag = TAG_DELETED;
					cnt_dec = (count_q != '0);
					chk_status = ST_DELETED;
				end
			end
			default: begin
				// search, and the unused request code which behaves as one
				chk_status = ST_NOT_FOUND;
				if (rd_tag == TAG_EMPTY) begin
					chk_done = 1'b1;
				end else if (hit) begin
					chk_done = 1'b1;
					chk_status = ST_FOUND;
				end
			end
		endcase
		if (probe_q == LAST_PROBE) begin
			chk_done = 1'b1;
		end
	end

	// write port: clearing pass, or the update at the end of a probe
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = AW'(pg_slot);
		mem_wdata = {chk_tag, key_q};
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = {TAG_EMPTY, {KEY_W{1'b0}}};
		end else if (state_q == S_CHECK) begin
			mem_we = chk_write;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[AW'(pg_slot)];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			table_size_q <= SIZE_W'(64);
			clr_addr_q <= '0;
			probe_q <= '0;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				table_size_q <= cfg_wdata;
			end
			// in S_DONE the output word is reloaded below instead
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						probe_q <= '0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (pg_ready) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (cnt_inc) begin
						count_q <= count_q + 1'b1;
					end else if (cnt_dec) begin
						count_q <= count_q - 1'b1;
					end
					if (chk_done) begin
						state_q <= S_DONE;
					end else begin
						probe_q <= probe_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result words
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= req_type;
			key_q <= key;
		end
		if (state_q == S_CHECK && chk_done) begin
			res_status_q <= chk_status;
			res_slot_q <= (chk_status == ST_INSERTED || chk_status == ST_FOUND
			               || chk_status == ST_DELETED) ? pg_slot : '0;
		end
		if (state_q == S_DONE && out_free) begin
			out_status_q <= res_status_q;
			out_slot_q <= 6'(res_slot_q);
			out_count_q <= 7'(count_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign slot = out_slot_q;
	assign live_count = out_count_q;

`ifndef SYNTHESIS
	a_accept_starts_hash: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_HASH)
		else $error("accepted word did not start hashing");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("live count beyond table depth");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_q <= LAST_PROBE)
		else $error("probe counter past limit");
	a_search_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && op_q != OP_INSERT && op_q != OP_DELETE) |-> !mem_we)
		else $error("search wrote the table");
	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_free) |=> state_q == S_DONE)
		else $error("result dropped while output busy");
`endif

endmodule

// ----- rtl/qpht_probe_gen.sv -----
// probe slot generator: radix-4 hash reduction and incremental quadratic offsets
module qpht_probe_gen (
	input  logic                         clk,
	input  logic                         arst_n,
	input  qpht_pkg::pg_ctrl_t           ctrl,
	input  logic [qpht_pkg::KEY_W-1:0]   key,
	input  logic [qpht_pkg::SIZE_W-1:0]  size,
	output logic                         ready,
	output logic [qpht_pkg::SIZE_W-1:0]  slot
);
	import qpht_pkg::*;

	logic                   hash_q;
	logic                   valid_q;
	logic [DIGIT_CNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]      val_q;
	logic [SIZE_W-1:0]      rem_q;
	logic [SIZE_W-1:0]      size_q;
	logic [SIZE_W-1:0]      base_q;
	logic [SIZE_W-1:0]      sq_q;
	logic [SIZE_W-1:0]      odd_q;

	logic [SIZE_W+1:0]      dig_v;
	logic [SIZE_W+1:0]      s1;
	logic [SIZE_W+1:0]      s2;
	logic [SIZE_W+1:0]      s3;
	logic [SIZE_W-1:0]      rem_nxt;
	logic [SIZE_W:0]        sum_slot;
	logic [SIZE_W:0]        sum_sq;
	logic [SIZE_W:0]        odd_a;
	logic [SIZE_W:0]        odd_b;
	logic [SIZE_W-1:0]      sq_nxt;
	logic [SIZE_W-1:0]      odd_nxt;
	logic [HASH_W-1:0]      hash_in;

	// radix-4 digit: remainder times four plus two bits, less the largest fitting multiple
	always_comb begin
		dig_v = {rem_q, val_q[HASH_W-1 -: 2]};
		s1 = {2'b00, size_q};
		s2 = {1'b0, size_q, 1'b0};
		s3 = s1 + s2;
		if (dig_v >= s3) begin
			rem_nxt = SIZE_W'(dig_v - s3);
		end else if (dig_v >= s2) begin
			rem_nxt = SIZE_W'(dig_v - s2);
		end else if (dig_v >= s1) begin
			rem_nxt = SIZE_W'(dig_v - s1);
		end else begin
			rem_nxt = SIZE_W'(dig_v);
		end
	end

	// (j+1)^2 = j^2 + (2j+1), both kept reduced
	always_comb begin
		sum_sq = {1'b0, sq_q} + {1'b0, odd_q};
		sq_nxt = (sum_sq >= {1'b0, size_q}) ? SIZE_W'(sum_sq - {1'b0, size_q}) : SIZE_W'(sum_sq);
		odd_a = {1'b0, odd_q} + (SIZE_W + 1)'(2);
		if (odd_a >= {1'b0, size_q}) begin
			odd_a = odd_a - {1'b0, size_q};
		end
		odd_b = odd_a;
		if (odd_b >= {1'b0, size_q}) begin
			odd_b = odd_b - {1'b0, size_q};
		end
		odd_nxt = SIZE_W'(odd_b);
		sum_slot = {1'b0, base_q} + {1'b0, sq_q};
		slot = (sum_slot >= {1'b0, size_q}) ? SIZE_W'(sum_slot - {1'b0, size_q})
		                                    : SIZE_W'(sum_slot);
	end

	assign hash_in = {2'b00, key, 1'b0} + {3'b000, key} + HASH_W'(3);
	assign ready = valid_q && !hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= 1'b0;
			valid_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctrl.start) begin
			hash_q <= 1'b1;
			valid_q <= 1'b0;
			cnt_q <= DIGIT_CNT_W'(HASH_DIGITS);
		end else if (hash_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIGIT_CNT_W'(1)) begin
				hash_q <= 1'b0;
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			val_q <= hash_in;
			rem_q <= '0;
			size_q <= size;
			sq_q <= '0;
			odd_q <= (size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
		end else if (hash_q) begin
			val_q <= {val_q[HASH_W-3:0], 2'b00};
			rem_q <= rem_nxt;
			if (cnt_q == DIGIT_CNT_W'(1)) begin
				base_q <= rem_nxt;
			end
		end else if (ctrl.advance) begin
			sq_q <= sq_nxt;
			odd_q <= odd_nxt;
		end
	end

`ifndef SYNTHESIS
	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		hash_q |-> rem_q < size_q)
		else $error("hash remainder not reduced");
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		hash_q |-> cnt_q != '0)
		else $error("digit counter ran out while hashing");
	a_probe_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		ready |-> (base_q < size_q) && (sq_q < size_q) && (odd_q < size_q) && (slot < size_q))
		else $error("probe terms out of range");
`endif

endmodule
